// File: rtl/core/sprt_pkg.sv
// Shared types and constants for the scan peer RSSI table.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package sprt_pkg;

	// Field widths fixed by the report and result formats
	localparam int ADDR_W   = 48;
	localparam int RSSI_W   = 8;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int TOTAL_W  = 5;

	// Default table depth
	localparam int TABLE_DEPTH_DEF = 16;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_SAMPLE_LIMIT = 1'b0;
	localparam logic [CNT_W-1:0] SAMPLE_LIMIT_RST = 8'd10;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_AT_LIMIT = 3'd2,
		ST_INSERTED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// One table entry
	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic signed [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]         cnt;
		logic signed [RSSI_W-1:0] avg;
	} entry_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic             negate;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/core/sprt_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on sprt_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module sprt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sprt_pkg::div_req_t req,
	output sprt_pkg::div_rsp_t rsp
);

	localparam int SW     = sprt_pkg::SUM_W;
	localparam int CW     = sprt_pkg::CNT_W;
	localparam int STEP_W = $clog2(SW + 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CW-1:0]     dvs_q;
	logic [CW-1:0]     rem_q;
	logic [SW-1:0]     quo_q;
	logic [STEP_W-1:0] step_q;

	logic [CW:0]   trial;
	logic          fits;
	logic [CW-1:0] rem_next;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial    = {rem_q, quo_q[SW-1]};
		fits     = trial >= {1'b0, dvs_q};
		rem_next = fits ? CW'(trial - {1'b0, dvs_q}) : trial[CW-1:0];
	end

	// Shift one dividend bit in and one quotient bit out per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			dvs_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			step_q <= '0;
		end else begin
			// Flag the result after the last quotient bit
			done_q <= !req.start && busy_q && (step_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.negate;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				step_q <= STEP_W'(SW);
			end else if (busy_q) begin
				rem_q  <= rem_next;
				quo_q  <= {quo_q[SW-2:0], fits};
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Restore the sign: truncation toward zero
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + SW'(1)) : quo_q;

endmodule

// File: rtl/core/sprt_cfg.sv
// APB-style register file holding the per-peer sample limit.
// Depends on sprt_pkg for address decode and reset value.
`timescale 1ns / 1ps

module sprt_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sprt_pkg::PADDR_W-1:0]      paddr,
	input  logic [sprt_pkg::PDATA_W-1:0]      pwdata,
	output logic [sprt_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	output logic [sprt_pkg::CNT_W-1:0]        sample_limit
);

	logic [sprt_pkg::CNT_W-1:0] limit_q;
	logic                       hit;

	// Decode on the word index, ignoring byte lanes
	assign hit    = paddr[sprt_pkg::PADDR_W-1:2] == sprt_pkg::REG_SAMPLE_LIMIT;
	assign pready = 1'b1;

	// Take the write beat in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sprt_pkg::SAMPLE_LIMIT_RST;
		end else if (psel && penable && pwrite && hit) begin
			limit_q <= pwdata[sprt_pkg::CNT_W-1:0];
		end
	end

	assign prdata = hit ? sprt_pkg::PDATA_W'(limit_q) : '0;
	assign sample_limit = limit_q;

endmodule

// File: rtl/core/scan_peer_rssi_table_top.sv
// Top level of the scan peer RSSI table: sequencer, entry memory and result register.
// Depends on sprt_pkg, sprt_cfg and sprt_div.
`timescale 1ns / 1ps

// Takes one advertising report per beat and returns one result beat per report. Reports
// with the table full or the service flag clear skip the table. Otherwise the
// sequencer walks the entry memory one entry at a time (read, then compare on the
// registered read data): a new peer is appended after the last stored entry, a
// known peer at its sample limit is returned as it stands, and otherwise its average
// is recomputed by the shared divider that yields one quotient bit per cycle over
// the 16-bit sum. The block takes no
// new report while one is at work; a finished result may wait in the output register
// while the next report is accepted. The entry memory needs no clearing after reset.
module scan_peer_rssi_table_top #(
	parameter int TABLE_DEPTH = sprt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sprt_pkg::PADDR_W-1:0]        paddr,
	input  logic [sprt_pkg::PDATA_W-1:0]        pwdata,
	output logic [sprt_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sprt_pkg::ADDR_W-1:0]         peer_address,
	input  logic signed [sprt_pkg::RSSI_W-1:0]  signal_strength,
	input  logic                                service_match,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sprt_pkg::STATUS_W-1:0]       status,
	output logic [sprt_pkg::SLOT_W-1:0]         slot,
	output logic signed [sprt_pkg::RSSI_W-1:0]  average_strength,
	output logic [sprt_pkg::CNT_W-1:0]          sample_count,
	output logic [sprt_pkg::TOTAL_W-1:0]        peer_total
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PC_W  = $clog2(TABLE_DEPTH + 1);
	localparam int AW    = sprt_pkg::ADDR_W;
	localparam int RW    = sprt_pkg::RSSI_W;
	localparam int SW    = sprt_pkg::SUM_W;
	localparam int CW    = sprt_pkg::CNT_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_CMP  = 6'b000100,
		S_DIV  = 6'b001000,
		S_INS  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         idx_q;
	logic [PC_W-1:0]          peer_count_q;
	logic [AW-1:0]            addr_q;
	logic signed [RW-1:0]     rssi_q;
	logic signed [SW-1:0]     sum_q;
	logic [CW-1:0]            cnt_q;

	sprt_pkg::status_t        res_status_q;
	logic [sprt_pkg::SLOT_W-1:0] res_slot_q;
	logic signed [RW-1:0]     res_avg_q;
	logic [CW-1:0]            res_cnt_q;

	logic                     out_valid_q;
	logic [sprt_pkg::STATUS_W-1:0] status_q;
	logic [sprt_pkg::SLOT_W-1:0]   slot_q;
	logic signed [RW-1:0]     avg_q;
	logic [CW-1:0]            count_q;
	logic [sprt_pkg::TOTAL_W-1:0]  total_q;

	logic [CW-1:0]            sample_limit;
	sprt_pkg::div_req_t       div_req;
	sprt_pkg::div_rsp_t       div_rsp;

	sprt_pkg::entry_t         mem [TABLE_DEPTH];
	sprt_pkg::entry_t         rd_data_q;
	sprt_pkg::entry_t         wr_data;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_idx;

	logic                     full;
	logic                     hit;
	logic                     last;
	logic                     at_limit;
	logic signed [SW-1:0]     rssi_ext;
	logic signed [SW-1:0]     new_sum;
	logic                     out_free;

	// Configuration registers
	sprt_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_limit (sample_limit)
	);

	// Shared divider for the running average
	sprt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Scan and update decisions
	always_comb begin
		full     = peer_count_q >= PC_W'(TABLE_DEPTH);
		hit      = rd_data_q.addr == addr_q;
		last     = (PC_W'(idx_q) + PC_W'(1)) == peer_count_q;
		at_limit = rd_data_q.cnt >= sample_limit;
		rssi_ext = {{(SW-RW){rssi_q[RW-1]}}, rssi_q};
		new_sum  = rd_data_q.sum + rssi_ext;
		out_free = !out_valid_q || !out_stall;
	end

	// Kick the divider with the magnitude of the new sum
	always_comb begin
		div_req.start    = (state_q == S_CMP) && hit && !at_limit;
		div_req.negate   = new_sum[SW-1];
		div_req.dividend = new_sum[SW-1] ? (~new_sum + SW'(1)) : new_sum;
		div_req.divisor  = rd_data_q.cnt + CW'(1);
	end

	// Entry write: append a new peer or store an updated average
	always_comb begin
		wr_en  = (state_q == S_INS) || ((state_q == S_DIV) && div_rsp.done);
		wr_idx = (state_q == S_INS) ? IDX_W'(peer_count_q) : idx_q;
		if (state_q == S_INS) begin
			wr_data.addr = addr_q;
			wr_data.sum  = rssi_ext;
			wr_data.cnt  = CW'(1);
			wr_data.avg  = rssi_q;
		end else begin
			wr_data.addr = addr_q;
			wr_data.sum  = sum_q;
			wr_data.cnt  = cnt_q;
			wr_data.avg  = div_rsp.quotient[RW-1:0];
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_data_q <= mem[idx_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			peer_count_q <= '0;
			addr_q       <= '0;
			rssi_q       <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			res_status_q <= sprt_pkg::ST_IGNORED;
			res_slot_q   <= '0;
			res_avg_q    <= '0;
			res_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= '0;
			slot_q       <= '0;
			avg_q        <= '0;
			count_q      <= '0;
			total_q      <= '0;
		end else begin
			// Drop the result once the beat is taken, unless the next one replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						addr_q     <= peer_address;
						rssi_q     <= signal_strength;
						idx_q      <= '0;
						res_slot_q <= '0;
						res_avg_q  <= '0;
						res_cnt_q  <= '0;
						if (full) begin
							res_status_q <= sprt_pkg::ST_FULL;
							state_q      <= S_DONE;
						end else if (!service_match) begin
							res_status_q <= sprt_pkg::ST_IGNORED;
							state_q      <= S_DONE;
						end else if (peer_count_q == '0) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						res_slot_q <= sprt_pkg::SLOT_W'(idx_q);
						if (at_limit) begin
							res_status_q <= sprt_pkg::ST_AT_LIMIT;
							res_avg_q    <= rd_data_q.avg;
							res_cnt_q    <= rd_data_q.cnt;
							state_q      <= S_DONE;
						end else begin
							sum_q   <= new_sum;
							cnt_q   <= rd_data_q.cnt + CW'(1);
							state_q <= S_DIV;
						end
					end else if (last) begin
						state_q <= S_INS;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_status_q <= sprt_pkg::ST_UPDATED;
						res_avg_q    <= div_rsp.quotient[RW-1:0];
						res_cnt_q    <= cnt_q;
						state_q      <= S_DONE;
					end
				end
				S_INS: begin
					peer_count_q <= peer_count_q + PC_W'(1);
					res_status_q <= sprt_pkg::ST_INSERTED;
					res_slot_q   <= sprt_pkg::SLOT_W'(peer_count_q);
					res_avg_q    <= rssi_q;
					res_cnt_q    <= CW'(1);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						slot_q      <= res_slot_q;
						avg_q       <= res_avg_q;
						count_q     <= res_cnt_q;
						total_q     <= sprt_pkg::TOTAL_W'(peer_count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall         = state_q != S_IDLE;
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign slot             = slot_q;
	assign average_strength = avg_q;
	assign sample_count     = count_q;
	assign peer_total       = total_q;

	// The table never holds more peers than it has entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		peer_count_q <= PC_W'(TABLE_DEPTH))
		else $error("peer count beyond table depth");

	// The peer count only ever grows by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(peer_count_q != $past(peer_count_q)) |-> (peer_count_q == $past(peer_count_q) + PC_W'(1)))
		else $error("peer count changed by more than one");

	// A divide result arrives only while the sequencer waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	// Refused and ignored reports touch no entry
	a_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == sprt_pkg::ST_FULL || status == sprt_pkg::ST_IGNORED))
		|-> (slot == '0 && sample_count == '0 && average_strength == '0))
		else $error("untouched result carries entry data");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for scan_peer_rssi_table_top: streams advertising reports,
// predicts every result beat from a behavioural copy of the peer table and compares.
// Depends on sprt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;

	localparam int ADDR_W   = sprt_pkg::ADDR_W;
	localparam int RSSI_W   = sprt_pkg::RSSI_W;
	localparam int SUM_W    = sprt_pkg::SUM_W;
	localparam int CNT_W    = sprt_pkg::CNT_W;
	localparam int STATUS_W = sprt_pkg::STATUS_W;
	localparam int SLOT_W   = sprt_pkg::SLOT_W;
	localparam int TOTAL_W  = sprt_pkg::TOTAL_W;
	localparam int PADDR_W  = sprt_pkg::PADDR_W;
	localparam int PDATA_W  = sprt_pkg::PDATA_W;

	localparam int DEPTH          = sprt_pkg::TABLE_DEPTH_DEF;
	localparam int IDLE_PCT       = 29;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLDOFF_AT     = 40;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 60;
	localparam int MAX_REPORTS    = 10;
	localparam int POOL_SIZE      = 15;
	localparam int HOT_PEER       = 2;

	localparam logic [PADDR_W-1:0] ADDR_LIMIT    = PADDR_W'(4 * sprt_pkg::REG_SAMPLE_LIMIT);
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);

	localparam logic signed [RSSI_W-1:0] RSSI_MIN = -128;
	localparam logic signed [RSSI_W-1:0] RSSI_MAX = 127;

	typedef struct {
		logic [ADDR_W-1:0]        addr;
		logic signed [RSSI_W-1:0] rssi;
		logic                     match;
	} report_t;

	typedef struct {
		sprt_pkg::status_t        status;
		logic [SLOT_W-1:0]        slot;
		logic signed [RSSI_W-1:0] avg;
		logic [CNT_W-1:0]         cnt;
		logic [TOTAL_W-1:0]       total;
	} peer_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [PADDR_W-1:0]         paddr = '0;
	logic [PDATA_W-1:0]         pwdata = '0;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [ADDR_W-1:0]          peer_address = '0;
	logic signed [RSSI_W-1:0]   signal_strength = '0;
	logic                       service_match = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic [SLOT_W-1:0]          slot;
	logic signed [RSSI_W-1:0]   average_strength;
	logic [CNT_W-1:0]           sample_count;
	logic [TOTAL_W-1:0]         peer_total;

	// Traffic control
	report_t      pending_reports[$];
	peer_result_t expected_results[$];
	report_t      offered;
	logic         report_on_bus = 1'b0;
	logic         calm = 1'b0;
	int           bad_results = 0;
	int           quiet_cycles = 0;
	logic [ADDR_W-1:0] peer_pool[POOL_SIZE];

	// Behavioural copy of the peer table
	logic [ADDR_W-1:0]        peer_addr_q[DEPTH];
	logic signed [SUM_W-1:0]  peer_sum_q[DEPTH];
	logic [CNT_W-1:0]         peer_cnt_q[DEPTH];
	logic signed [RSSI_W-1:0] peer_avg_q[DEPTH];
	int                       peers_known = 0;
	logic [CNT_W-1:0]         limit_model = sprt_pkg::SAMPLE_LIMIT_RST;

	scan_peer_rssi_table_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.peer_address     (peer_address),
		.signal_strength  (signal_strength),
		.service_match    (service_match),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.slot             (slot),
		.average_strength (average_strength),
		.sample_count     (sample_count),
		.peer_total       (peer_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one report to the table copy and return the result beat it should give
	function automatic peer_result_t predict_peer_result(report_t rep);
		peer_result_t res;
		int hit;
		int idx;
		int sum;
		int cnt;
		res = '{sprt_pkg::ST_IGNORED, '0, '0, '0, '0};
		hit = -1;
		if (peers_known >= DEPTH) begin
			// full table refuses everything, known peers and clear flags alike
			res.status = sprt_pkg::ST_FULL;
		end else if (rep.match) begin
			for (idx = 0; idx < peers_known; idx++)
				if (hit < 0 && peer_addr_q[idx] == rep.addr)
					hit = idx;
			if (hit < 0) begin
				peer_addr_q[peers_known] = rep.addr;
				peer_sum_q[peers_known]  = SUM_W'(rep.rssi);
				peer_cnt_q[peers_known]  = CNT_W'(1);
				peer_avg_q[peers_known]  = rep.rssi;
				res = '{sprt_pkg::ST_INSERTED, SLOT_W'(peers_known), rep.rssi,
					CNT_W'(1), '0};
				peers_known++;
			end else if (peer_cnt_q[hit] < limit_model) begin
				sum = int'(peer_sum_q[hit]) + int'(rep.rssi);
				cnt = int'(peer_cnt_q[hit]) + 1;
				peer_sum_q[hit] = SUM_W'(sum);
				peer_cnt_q[hit] = CNT_W'(cnt);
				// integer division truncates toward zero
				peer_avg_q[hit] = RSSI_W'(sum / cnt);
				res = '{sprt_pkg::ST_UPDATED, SLOT_W'(hit), peer_avg_q[hit],
					peer_cnt_q[hit], '0};
			end else begin
				res = '{sprt_pkg::ST_AT_LIMIT, SLOT_W'(hit), peer_avg_q[hit],
					peer_cnt_q[hit], '0};
			end
		end
		res.total = TOTAL_W'(peers_known);
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_address();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	// Report driver: offer queued reports, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			peer_address    <= '0;
			signal_strength <= '0;
			service_match   <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_peer_result(offered));
				report_on_bus = 1'b0;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reports.size() != 0 &&
					(calm || $urandom_range(99) >= IDLE_PCT)) begin
					offered = pending_reports.pop_front();
					report_on_bus = 1'b1;
					in_valid        <= 1'b1;
					peer_address    <= offered.addr;
					signal_strength <= offered.rssi;
					service_match   <= offered.match;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each beat and drive random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin : result_monitor
		peer_result_t want;
		int results_seen;
		int holdoff;
		bit held;
		if (!arst_n) begin
			out_stall <= 1'b0;
			results_seen = 0;
			holdoff = 0;
			held = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("error: result beat %0d with nothing expected (status %0d)",
							results_seen, status);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || slot !== want.slot ||
						average_strength !== want.avg || sample_count !== want.cnt ||
						peer_total !== want.total) begin
						bad_results++;
						if (bad_results <= MAX_REPORTS)
							$display("error: beat %0d exp st %0d sl %0d avg %0d cnt %0d tot %0d",
								results_seen, want.status, want.slot, want.avg, want.cnt,
								want.total,
								", got st %0d sl %0d avg %0d cnt %0d tot %0d",
								status, slot, average_strength, sample_count, peer_total);
					end
				end
			end
			if (holdoff != 0) begin
				holdoff--;
				out_stall <= 1'b1;
			end else if (results_seen == HOLDOFF_AT && !held) begin
				// hold the output long enough for the input side to back up
				held = 1'b1;
				holdoff = HOLDOFF_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("scan_peer_rssi_table_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_report(logic [ADDR_W-1:0] a, logic signed [RSSI_W-1:0] r, logic m);
		report_t rep;
		rep = '{a, r, m};
		pending_reports.push_back(rep);
	endtask

	// Mix of pool peers, an optional hot peer, clear flags and stranger noise
	task automatic add_random(int n, int pool_n, int hot_pct);
		int k;
		int pick;
		logic [ADDR_W-1:0] a;
		logic signed [RSSI_W-1:0] r;
		logic m;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				a = rand_address();
				m = 1'b0;
			end else begin
				if ($urandom_range(99) < hot_pct)
					a = peer_pool[HOT_PEER];
				else
					a = peer_pool[$urandom_range(pool_n - 1)];
				m = (pick >= 14);
			end
			case ($urandom_range(7))
				0:       r = RSSI_MIN;
				1:       r = RSSI_MAX;
				default: r = RSSI_W'($urandom);
			endcase
			add_report(a, r, m);
		end
	endtask

	task automatic wait_idle();
		while (pending_reports.size() != 0 || expected_results.size() != 0 || report_on_bus)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Two-phase register write; the model follows at the access edge
	task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == ADDR_LIMIT)
			limit_model = d[CNT_W-1:0];
	endtask

	initial begin : stimulus
		int k;
		int j;
		bit dup;
		logic [ADDR_W-1:0] a;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Build a pool of distinct peers, the all-zero and all-one addresses first
		peer_pool[0] = '0;
		peer_pool[1] = '1;
		for (k = 2; k < POOL_SIZE; k++) begin
			do begin
				a = rand_address();
				dup = 1'b0;
				for (j = 0; j < k; j++)
					if (peer_pool[j] == a)
						dup = 1'b1;
			end while (dup);
			peer_pool[k] = a;
		end

		// Directed: empty-table ignore, extremes, truncation, clear flag, sample limit
		add_report(peer_pool[1], 8'sd0, 1'b0);
		add_report(peer_pool[0], RSSI_MIN, 1'b1);
		add_report(peer_pool[1], RSSI_MAX, 1'b1);
		add_report(peer_pool[0], RSSI_MIN, 1'b1);
		add_report(peer_pool[1], RSSI_MAX, 1'b1);
		add_report(peer_pool[0], RSSI_MAX, 1'b1);
		add_report(peer_pool[0], 8'sd0, 1'b1);
		add_report(peer_pool[1], -8'sd1, 1'b1);
		add_report(peer_pool[0], 8'sd5, 1'b0);
		for (k = 0; k < 11; k++)
			add_report(peer_pool[HOT_PEER], RSSI_W'($urandom), 1'b1);
		wait_idle();

		// Reset limit, a handful of peers hitting it
		add_random(80, 8, 0);
		wait_idle();

		// Limit of zero: every known peer sits at the limit
		apb_write(ADDR_LIMIT, 0);
		add_random(30, 11, 0);
		wait_idle();

		// Limit of one; a write to an unmapped register must change nothing
		apb_write(ADDR_LIMIT, 1);
		apb_write(ADDR_UNMAPPED, 200);
		add_random(40, 12, 0);
		wait_idle();

		// Highest limit: drive the hot peer all the way to 255 samples, first stretch calm
		apb_write(ADDR_LIMIT, 255);
		calm <= 1'b1;
		add_random(320, 12, 97);
		while (pending_reports.size() > 220)
			@(posedge clk);
		calm <= 1'b0;
		wait_idle();

		apb_write(ADDR_LIMIT, 200);
		add_random(40, POOL_SIZE, 0);
		wait_idle();

		// Fill the table, then everything is refused
		for (k = 0; k < DEPTH; k++)
			add_report(rand_address(), RSSI_W'($urandom), 1'b1);
		add_random(20, POOL_SIZE, 0);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		bad_results += expected_results.size();
		if (bad_results == 0)
			$display("scan_peer_rssi_table_top: match");
		else
			$display("scan_peer_rssi_table_top: mismatch");
		$finish;
	end

endmodule
